// ----- sv/srpt_pkg.sv -----
`default_nettype none
package srpt_pkg;
   localparam int unsigned HeapDepthDefault = 32;
   localparam int unsigned TimeW = 38;
   localparam int unsigned RemW = 25;
   localparam int unsigned SumW = 64;
   localparam int unsigned OrderW = 64;

   localparam logic [1:0] StDone = 2'd0;
   localparam logic [1:0] StRunDone = 2'd1;
   localparam logic [1:0] StOrder = 2'd2;
   localparam logic [1:0] StFull = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_RD_TOP,
      S_TOP_WAIT,
      S_DECIDE,
      S_EMIT,
      S_POP_LAST,
      S_POP_LAST_WAIT,
      S_SIFT_RD,
      S_SIFT_WAIT,
      S_SIFT_CMP,
      S_INS,
      S_UP_RD,
      S_UP_WAIT,
      S_UP_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [15:0] tag;
      logic [31:0] arr;
      logic [OrderW-1:0] ord;
   } entry_type;

   function automatic logic precedes(entry_type a, entry_type b);
      if (a.rem != b.rem) return a.rem < b.rem;
      return a.ord < b.ord;
   endfunction
endpackage
`default_nettype wire

// ----- sv/srpt_preemptive_scheduler_core.sv -----
`default_nettype none
// Channel | Direction | Signals
// req     | in        | req_valid/req_ready, arrival_time, exec_time, task_tag, last_task
// rsp     | out       | rsp_valid/rsp_ready, done_tag, finish_time, response_time,
//         |           | total_response, status, last
// One request is handled at a time; req_ready is high only when the sequencer is idle.
// A request emits the completions due by its arrival, then inserts its entry level by level.
// Each completion moves the last entry to the top and sifts it down level by level.
// All heap steps share a single entry memory with one read port and one write port.
// Reset is synchronous and clears the control state and the heap count.
// A stalled rsp holds the sequencer wherever it next needs the output register.
module srpt_preemptive_scheduler_core #(
   parameter int unsigned HEAP_DEPTH = srpt_pkg::HeapDepthDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [31:0] req_arrival_time,
   input wire logic [23:0] req_exec_time,
   input wire logic [15:0] req_task_tag,
   input wire logic req_last_task,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [15:0] rsp_done_tag,
   output logic [37:0] rsp_finish_time,
   output logic [37:0] rsp_response_time,
   output logic [63:0] rsp_total_response,
   output logic [1:0] rsp_status,
   output logic rsp_last
);
   import srpt_pkg::*;

   localparam int unsigned IdxW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(HEAP_DEPTH + 1);

   entry_type mem [HEAP_DEPTH];
   entry_type rd_ff;
   logic [IdxW-1:0] raddr;
   logic we;
   logic [IdxW-1:0] waddr;
   entry_type wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [TimeW-1:0] time_ff, time_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic active_ff, active_in;
   logic [OrderW-1:0] order_ff, order_in;
   logic [31:0] arr_ff, arr_in;
   logic [23:0] exe_ff, exe_in;
   logic [15:0] tag_ff, tag_in;
   logic lastt_ff, lastt_in;
   logic drain_ff, drain_in;
   entry_type top_ff, top_in;
   entry_type cur_ff, cur_in;
   entry_type best_ff, best_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic [IdxW-1:0] bidx_ff, bidx_in;
   logic [1:0] child_ff, child_in;
   logic ov_ff, ov_in;
   logic [15:0] otag_ff, otag_in;
   logic [TimeW-1:0] ofin_ff, ofin_in, oresp_ff, oresp_in;
   logic [SumW-1:0] osum_ff, osum_in;
   logic [1:0] ost_ff, ost_in;
   logic olast_ff, olast_in;
   logic sg_ff, sg_in;
   logic [15:0] sgtag_ff, sgtag_in;
   logic [TimeW-1:0] sgfin_ff, sgfin_in, sgresp_ff, sgresp_in;
   logic [SumW-1:0] sgsum_ff, sgsum_in;
   logic [1:0] sgst_ff, sgst_in;

   logic [TimeW-1:0] gap, fin, resp;
   logic [SumW:0] sum_ext;
   logic [IdxW:0] lchild;
   logic [IdxW:0] rchild;
   logic more_done;

   assign gap = {6'd0, arr_ff} - time_ff;
   assign fin = time_ff + TimeW'(top_ff.rem);
   assign resp = fin - {6'd0, top_ff.arr};
   assign sum_ext = {1'b0, sum_ff} + {{(SumW + 1 - TimeW){1'b0}}, resp};
   assign lchild = {pos_ff, 1'b1};
   assign rchild = {pos_ff, 1'b0} + (IdxW + 1)'(2);
   assign more_done = count_ff != '0 && (drain_ff || {13'd0, top_ff.rem} <= gap);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         time_ff <= '0;
         sum_ff <= '0;
         active_ff <= 1'b0;
         order_ff <= '0;
         ov_ff <= 1'b0;
         sg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         time_ff <= time_in;
         sum_ff <= sum_in;
         active_ff <= active_in;
         order_ff <= order_in;
         ov_ff <= ov_in;
         sg_ff <= sg_in;
      end
      arr_ff <= arr_in; exe_ff <= exe_in; tag_ff <= tag_in; lastt_ff <= lastt_in;
      drain_ff <= drain_in;
      top_ff <= top_in; cur_ff <= cur_in; best_ff <= best_in;
      pos_ff <= pos_in; bidx_ff <= bidx_in; child_ff <= child_in;
      otag_ff <= otag_in; ofin_ff <= ofin_in; oresp_ff <= oresp_in;
      osum_ff <= osum_in; ost_ff <= ost_in; olast_ff <= olast_in;
      sgtag_ff <= sgtag_in; sgfin_ff <= sgfin_in; sgresp_ff <= sgresp_in;
      sgsum_ff <= sgsum_in; sgst_ff <= sgst_in;
   end

   // Next state and datapath.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff; time_in = time_ff; sum_in = sum_ff;
      active_in = active_ff; order_in = order_ff;
      arr_in = arr_ff; exe_in = exe_ff; tag_in = tag_ff; lastt_in = lastt_ff;
      drain_in = drain_ff;
      top_in = top_ff; cur_in = cur_ff; best_in = best_ff;
      pos_in = pos_ff; bidx_in = bidx_ff; child_in = child_ff;
      ov_in = ov_ff; otag_in = otag_ff; ofin_in = ofin_ff; oresp_in = oresp_ff;
      osum_in = osum_ff; ost_in = ost_ff; olast_in = olast_ff;
      sg_in = sg_ff; sgtag_in = sgtag_ff; sgfin_in = sgfin_ff; sgresp_in = sgresp_ff;
      sgsum_in = sgsum_ff; sgst_in = sgst_ff;
      raddr = '0; we = 1'b0; waddr = '0; wdata = top_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               arr_in = req_arrival_time; exe_in = req_exec_time;
               tag_in = req_task_tag; lastt_in = req_last_task;
               drain_in = 1'b0;
               if (!active_ff) begin
                  active_in = 1'b1;
                  time_in = {6'd0, req_arrival_time};
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ({6'd0, arr_ff} < time_ff) begin
               if (!ov_ff) begin
                  ov_in = 1'b1; otag_in = tag_ff; ofin_in = '0; oresp_in = '0;
                  osum_in = sum_ff; ost_in = StOrder;
                  olast_in = !(lastt_ff && count_ff != '0);
                  state_in = S_FINISH;
               end
            end else state_in = S_RD_TOP;
         end
         S_RD_TOP: begin
            raddr = '0;
            state_in = (count_ff == '0) ? S_DECIDE : S_TOP_WAIT;
         end
         S_TOP_WAIT: begin
            top_in = rd_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!(sg_ff && ov_ff)) begin
               if (sg_ff) begin
                  // A staged completion ends the request only when nothing else
                  // completes now and no drain follows.
                  ov_in = 1'b1; otag_in = sgtag_ff; ofin_in = sgfin_ff;
                  oresp_in = sgresp_ff; osum_in = sgsum_ff; ost_in = sgst_ff;
                  olast_in = !more_done && (drain_ff || !lastt_ff);
                  sg_in = 1'b0;
               end
               if (more_done) begin
                  state_in = S_EMIT;
               end else if (!drain_ff) begin
                  if (count_ff != '0) begin
                     top_in.rem = top_ff.rem - gap[RemW-1:0];
                     we = 1'b1; waddr = '0; wdata = top_in;
                  end
                  time_in = {6'd0, arr_ff};
                  state_in = S_INS;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_EMIT: begin
            sg_in = 1'b1; sgtag_in = top_ff.tag; sgfin_in = fin; sgresp_in = resp;
            sgsum_in = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            sum_in = sgsum_in;
            time_in = fin;
            sgst_in = (drain_ff && count_ff == CntW'(1)) ? StRunDone : StDone;
            count_in = count_ff - CntW'(1);
            state_in = (count_ff == CntW'(1)) ? S_RD_TOP : S_POP_LAST;
         end
         S_POP_LAST: begin
            raddr = count_ff[IdxW-1:0];
            state_in = S_POP_LAST_WAIT;
         end
         S_POP_LAST_WAIT: begin
            cur_in = rd_ff; pos_in = '0;
            state_in = S_SIFT_RD;
         end
         S_SIFT_RD: begin
            best_in = cur_ff; bidx_in = pos_ff; child_in = 2'd0;
            if (lchild < (IdxW + 1)'(count_ff)) begin
               raddr = lchild[IdxW-1:0];
               state_in = S_SIFT_WAIT;
            end else begin
               we = 1'b1; waddr = pos_ff; wdata = cur_ff;
               state_in = S_RD_TOP;
            end
         end
         S_SIFT_WAIT: begin
            raddr = (child_ff == 2'd0) ? lchild[IdxW-1:0] : rchild[IdxW-1:0];
            state_in = S_SIFT_CMP;
         end
         S_SIFT_CMP: begin
            if (precedes(rd_ff, best_ff)) begin
               best_in = rd_ff;
               bidx_in = (child_ff == 2'd0) ? lchild[IdxW-1:0] : rchild[IdxW-1:0];
            end
            if (child_ff == 2'd0 && rchild < (IdxW + 1)'(count_ff)) begin
               child_in = 2'd1; raddr = rchild[IdxW-1:0];
               state_in = S_SIFT_WAIT;
            end else if (bidx_in == pos_ff) begin
               we = 1'b1; waddr = pos_ff; wdata = cur_ff;
               state_in = S_RD_TOP;
            end else begin
               we = 1'b1; waddr = pos_ff; wdata = best_in;
               pos_in = bidx_in;
               state_in = S_SIFT_RD;
            end
         end
         S_INS: begin
            if (count_ff >= CntW'(HEAP_DEPTH)) begin
               if (!ov_ff) begin
                  ov_in = 1'b1; otag_in = tag_ff; ofin_in = '0; oresp_in = '0;
                  osum_in = sum_ff; ost_in = StFull;
                  olast_in = !(lastt_ff && count_ff != '0);
                  state_in = S_FINISH;
               end
            end else begin
               cur_in.rem = {1'b0, exe_ff}; cur_in.tag = tag_ff; cur_in.arr = arr_ff;
               cur_in.ord = order_ff;
               order_in = order_ff + OrderW'(1);
               pos_in = count_ff[IdxW-1:0];
               count_in = count_ff + CntW'(1);
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               we = 1'b1; waddr = pos_ff; wdata = cur_ff;
               state_in = S_FINISH;
            end else begin
               raddr = (pos_ff - IdxW'(1)) >> 1;
               state_in = S_UP_WAIT;
            end
         end
         S_UP_WAIT: begin
            raddr = (pos_ff - IdxW'(1)) >> 1;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (precedes(cur_ff, rd_ff)) begin
               we = 1'b1; waddr = pos_ff; wdata = rd_ff;
               pos_in = (pos_ff - IdxW'(1)) >> 1;
               state_in = S_UP_RD;
            end else begin
               we = 1'b1; waddr = pos_ff; wdata = cur_ff;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (lastt_ff && !drain_ff) begin
               drain_in = 1'b1;
               state_in = S_RD_TOP;
            end else begin
               if (drain_ff) begin
                  count_in = '0; time_in = '0; sum_in = '0;
                  active_in = 1'b0; order_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      rsp_valid = ov_ff;
      rsp_done_tag = otag_ff;
      rsp_finish_time = ofin_ff;
      rsp_response_time = oresp_ff;
      rsp_total_response = osum_ff;
      rsp_status = ost_ff;
      rsp_last = olast_ff;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(HEAP_DEPTH)) else $error("heap count overflow");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready while busy");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == StOrder || rsp_status == StFull) |->
      rsp_finish_time == '0) else $error("rejection with time");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StRunDone |-> rsp_last) else $error("run done not last");
`endif
endmodule
`default_nettype wire
